/* hdl/fca_pkg.sv */
// Shared types and constants for the allocation table chain allocator.
// No dependencies; every other file imports this package.
package fca_pkg;

    localparam int NUM_BLOCKS       = 2048;
    localparam int FIRST_DATA_BLOCK = 2;

    // Port field widths are fixed by the transaction format.
    localparam int IDX_W = 11;
    localparam int CNT_W = IDX_W + 1;

    // Table address, link and cursor widths follow the table depth.
    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int PTR_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINK = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BLK_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [BLK_W-1:0] raddr;
    } tbl_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_LINK,
        ST_TAIL,
        ST_FREE,
        ST_LOOK,
        ST_RESP
    } state_t;

endpackage

/* hdl/fca_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on fca_pkg for the field widths.
interface fca_req_if
    import fca_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [IDX_W-1:0] block_index;
    logic [IDX_W-1:0] block_count;

    modport source (output valid, output op, output block_index, output block_count,
                    input ready);
    modport sink   (input valid, input op, input block_index, input block_count,
                    output ready);
endinterface

interface fca_rsp_if
    import fca_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic [IDX_W-1:0] result_block;
    logic [1:0]       entry_kind;

    modport source (output valid, output status, output result_block, output entry_kind,
                    input ready);
    modport sink   (input valid, input status, input result_block, input entry_kind,
                    output ready);
endinterface

/* hdl/fca_table.sv */
// Allocation table storage: one write port, one read port, registered read data.
// Depends on fca_pkg.
module fca_table
    import fca_pkg::*;
(
    input  logic     clk,
    input  tbl_req_t tbl_req,
    output entry_t   rd_data
);

    entry_t mem [NUM_BLOCKS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_req.we)
        begin
            mem[tbl_req.waddr] <= tbl_req.wdata;
        end
        if (tbl_req.re)
        begin
            rd_data_reg <= mem[tbl_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/fat_chain_allocator.sv */
// Allocation table chain allocator, top level.
// Depends on fca_pkg, fca_if (fca_req_if, fca_rsp_if) and fca_table.
//
// Usage:
//   req carries one command per transaction: op (format, allocate, free,
//   lookup), block_index and block_count. rsp returns exactly one
//   transaction per command: status, result_block and entry_kind.
//   Commands are handled one at a time; req.ready is high only while idle.
// Sequencing, set by the single table port pair and the scan sequencer:
//   format   sweeps the table, one table entry written per cycle
//   allocate count pass plus link pass, one entry per cycle each; a
//            refused allocation stops after the count pass; a zero
//            count answers without a scan
//   free     follows the chain, freeing each entry as its link is read
//   lookup   reads the requested entry when the index is in range
// Reset: the table is swept to its formatted state, one entry per cycle;
//   req.ready stays low during the sweep and no response transaction is
//   produced for it.
// Stall: the response sits in an output register; the next command is
//   accepted while it waits, and a later response waits for the slot.
module fat_chain_allocator
    import fca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fca_req_if.sink    req,
    fca_rsp_if.source  rsp
);

    state_t state_reg, state_next;

    // Control: cursor for clear/scan, scan pipeline, match counter
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic             clr_resp_reg, clr_resp_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [BLK_W-1:0] chk_addr_reg, chk_addr_next;
    logic [BLK_W-1:0] prev_reg, prev_next;
    logic [BLK_W-1:0] first_reg, first_next;
    logic             look_ok_reg, look_ok_next;
    logic             res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_block_reg, res_block_next;
    logic [1:0]       res_kind_reg, res_kind_next;
    logic             out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_block_reg, out_block_next;
    logic [1:0]       out_kind_reg, out_kind_next;

    tbl_req_t tbl_req;
    entry_t   rd_data;

    logic idx_ok;
    logic start_ok;
    logic hit;
    logic link_ok;

    fca_table u_table (
        .clk     (clk),
        .tbl_req (tbl_req),
        .rd_data (rd_data)
    );

    assign idx_ok   = 32'(req.block_index) < 32'(NUM_BLOCKS);
    assign start_ok = idx_ok && (32'(req.block_index) >= 32'(FIRST_DATA_BLOCK));
    assign hit      = chk_valid_reg && (rd_data.kind == KIND_FREE);
    assign link_ok  = (32'(rd_data.link) >= 32'(FIRST_DATA_BLOCK))
                   && (32'(rd_data.link) < 32'(NUM_BLOCKS));

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_block = out_block_reg;
    assign rsp.entry_kind   = out_kind_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        chk_valid_next  = chk_valid_reg;
        found_next      = found_reg;
        clr_resp_next   = clr_resp_reg;
        cnt_next        = cnt_reg;
        chk_addr_next   = chk_addr_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        look_ok_next    = look_ok_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_kind_next   = res_kind_reg;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_kind_next   = out_kind_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        tbl_req         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep: reserved blocks become end of chain, the rest free
                tbl_req.we          = 1'b1;
                tbl_req.waddr       = cur_reg[BLK_W-1:0];
                tbl_req.wdata.kind  = (32'(cur_reg) < 32'(FIRST_DATA_BLOCK)) ? KIND_END
                                                                             : KIND_FREE;
                tbl_req.wdata.link  = '0;
                cur_next            = cur_reg + 1'b1;
                if (cur_reg == PTR_W'(NUM_BLOCKS - 1))
                begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next        = req.block_count;
                    res_status_next = 1'b0;
                    res_block_next  = '0;
                    res_kind_next   = KIND_FREE;
                    unique case (op_t'(req.op))
                        OP_FORMAT:
                        begin
                            cur_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_ALLOC:
                        begin
                            if (req.block_count == '0)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                cur_next       = PTR_W'(FIRST_DATA_BLOCK);
                                chk_valid_next = 1'b0;
                                found_next     = '0;
                                state_next     = ST_COUNT;
                            end
                        end
                        OP_FREE:
                        begin
                            if (start_ok)
                            begin
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = BLK_W'(req.block_index);
                                chk_addr_next = BLK_W'(req.block_index);
                                state_next    = ST_FREE;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            tbl_req.re    = idx_ok;
                            tbl_req.raddr = BLK_W'(req.block_index);
                            look_ok_next  = idx_ok;
                            state_next    = ST_LOOK;
                        end
                    endcase
                end
            end

            ST_COUNT:
            begin
                // Streaming scan: issue one read per cycle, check each entry when its registered read data returns
                if (32'(cur_reg) < 32'(NUM_BLOCKS))
                begin
                    tbl_req.re     = 1'b1;
                    tbl_req.raddr  = cur_reg[BLK_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = cur_reg[BLK_W-1:0];
                    cur_next       = cur_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (hit)
                begin
                    found_next = found_reg + 1'b1;
                end
                priority if (hit && (found_reg + 1'b1 == CNT_W'(cnt_reg)))
                begin
                    cur_next       = PTR_W'(FIRST_DATA_BLOCK);
                    chk_valid_next = 1'b0;
                    found_next     = '0;
                    state_next     = ST_LINK;
                end
                else if (!chk_valid_reg && (cur_reg == PTR_W'(NUM_BLOCKS)))
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_RESP;
                end
                else
                begin
                end
            end

            ST_LINK:
            begin
                // Second pass: link each free block found from the previous one, until the requested count is reached
                if (32'(cur_reg) < 32'(NUM_BLOCKS))
                begin
                    tbl_req.re     = 1'b1;
                    tbl_req.raddr  = cur_reg[BLK_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_addr_next  = cur_reg[BLK_W-1:0];
                    cur_next       = cur_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (hit)
                begin
                    if (found_reg == '0)
                    begin
                        first_next = chk_addr_reg;
                    end
                    else
                    begin
                        tbl_req.we         = 1'b1;
                        tbl_req.waddr      = prev_reg;
                        tbl_req.wdata.kind = KIND_LINK;
                        tbl_req.wdata.link = chk_addr_reg;
                    end
                    prev_next  = chk_addr_reg;
                    found_next = found_reg + 1'b1;
                    if (found_reg + 1'b1 == CNT_W'(cnt_reg))
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_TAIL:
            begin
                tbl_req.we         = 1'b1;
                tbl_req.waddr      = prev_reg;
                tbl_req.wdata.kind = KIND_END;
                tbl_req.wdata.link = '0;
                res_block_next     = IDX_W'(first_reg);
                state_next         = ST_RESP;
            end

            ST_FREE:
            begin
                // Free the current entry and chase its link in the same cycle
                if (rd_data.kind == KIND_FREE)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    tbl_req.we         = 1'b1;
                    tbl_req.waddr      = chk_addr_reg;
                    tbl_req.wdata.kind = KIND_FREE;
                    tbl_req.wdata.link = '0;
                    if ((rd_data.kind == KIND_LINK) && link_ok)
                    begin
                        tbl_req.re    = 1'b1;
                        tbl_req.raddr = rd_data.link;
                        chk_addr_next = rd_data.link;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_LOOK:
            begin
                res_kind_next  = look_ok_reg ? rd_data.kind : KIND_FREE;
                res_block_next = (look_ok_reg && (rd_data.kind == KIND_LINK))
                               ? IDX_W'(rd_data.link) : '0;
                state_next     = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    out_kind_next   = res_kind_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        chk_addr_reg   <= chk_addr_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        look_ok_reg    <= look_ok_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_kind_reg   <= res_kind_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_kind_reg   <= out_kind_next;
    end

    // One command at a time: ready drops right after an accepted transaction
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("command accepted while another is in flight");

    // The table is never written while idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !tbl_req.we)
        else $error("table write while idle");

    // A new response only comes out of the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("response raised outside the response state");

    // A refused allocation carries no block and no kind
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> (rsp.result_block == '0) && (rsp.entry_kind == '0))
        else $error("disk-full response with nonzero payload");

endmodule
